// ===== design/scsc_pkg.sv =====
// Package for the solar charge switch controller.
// Holds field widths, register indexes, reset values and the sample word type.
// Depends on nothing.
package scsc_pkg;

   localparam int unsigned MvWidth    = 16;
   localparam int unsigned StepWidth  = 11;
   localparam int unsigned DacWidth   = 12;
   localparam int unsigned PeriodWidth = 8;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrDataWidth = 16;

   // Register indexes on the csr port
   localparam logic [CsrIdxWidth-1:0] CSR_BATTERY_FULL = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_PANEL_ON     = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_BATTERY_LOW  = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_PANEL_LOW    = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_DAC_STEP     = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_DAC_MAX      = 3'd5;
   localparam logic [CsrIdxWidth-1:0] CSR_REPORT_PERIOD = 3'd6;

   // Reset values of registers and state
   localparam logic [MvWidth-1:0]     BATTERY_FULL_RST  = 16'd12000;
   localparam logic [MvWidth-1:0]     PANEL_ON_RST      = 16'd20000;
   localparam logic [MvWidth-1:0]     BATTERY_LOW_RST   = 16'd10500;
   localparam logic [MvWidth-1:0]     PANEL_LOW_RST     = 16'd30000;
   localparam logic [StepWidth-1:0]   DAC_STEP_RST      = 11'd100;
   localparam logic [DacWidth-1:0]    DAC_MAX_RST       = 12'd1200;
   localparam logic [PeriodWidth-1:0] REPORT_PERIOD_RST = 8'd15;
   localparam logic [DacWidth-1:0]    DAC_LEVEL_RST     = 12'd1200;

   // One sample set as held in the input register
   typedef struct packed {
      logic [MvWidth-1:0] panel_volt_mv;
      logic [MvWidth-1:0] panel_curr_ma;
      logic [MvWidth-1:0] battery_volt_mv;
   } sample_type;

endpackage

// ===== design/solar_charge_switch_controller.sv =====
// Top level of the solar charge switch controller.
// One sample set in, one switch/setpoint word out; uses scsc_pkg.
// Contains the input register, the control logic and the result register.

// Every sample word passes through the input register and then the
// result register. While rsp_stall is low, a new word is accepted in
// every cycle, so the sustained rate is one word per clock; the only
// stall source is rsp_stall, which backs up through the two registers
// (req_stall rises when the input register is full and the result
// register cannot drain). Each word updates the battery and panel switch
// levels from the threshold registers (with a low-battery shutoff that
// overrides a close in the same word), tracks the peak panel current while
// the panel is on, and steps the converter setpoint down when the current
// rose or up when it fell, whenever the current sits below that peak. The
// setpoint is clamped to 0..dac_max_mv on every word with the panel on and
// dac_write marks those words. report_now fires when the 8-bit word counter
// equals report_period, which then clears the counter. Write csr registers
// only while no word is in flight.
module solar_charge_switch_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   // sample words
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [scsc_pkg::MvWidth-1:0]         req_panel_volt_mv,
   input  logic [scsc_pkg::MvWidth-1:0]         req_panel_curr_ma,
   input  logic [scsc_pkg::MvWidth-1:0]         req_battery_volt_mv,
   // result words
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_battery_switch,
   output logic                                 rsp_panel_switch,
   output logic [scsc_pkg::DacWidth-1:0]        rsp_dac_setpoint_mv,
   output logic                                 rsp_dac_write,
   output logic                                 rsp_report_now,
   // configuration
   input  logic                                 csr_write,
   input  logic [scsc_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [scsc_pkg::CsrDataWidth-1:0]    csr_data
);
   import scsc_pkg::*;

   // configuration registers
   logic [MvWidth-1:0]     battery_full_ff;
   logic [MvWidth-1:0]     panel_on_ff;
   logic [MvWidth-1:0]     battery_low_ff;
   logic [MvWidth-1:0]     panel_low_ff;
   logic [StepWidth-1:0]   dac_step_ff;
   logic [DacWidth-1:0]    dac_max_ff;
   logic [PeriodWidth-1:0] report_period_ff;

   // controller state
   logic                   bat_level_ff, bat_level_in;
   logic                   pan_level_ff, pan_level_in;
   logic [DacWidth-1:0]    dac_level_ff, dac_level_in;
   logic [MvWidth-1:0]     peak_curr_ff, peak_curr_in;
   logic [MvWidth-1:0]     last_curr_ff, last_curr_in;
   logic [PeriodWidth-1:0] report_cnt_ff, report_cnt_in;
   logic                   write_in, report_in;

   // pipeline registers
   logic                   s1_valid_ff;
   sample_type             s1_word_ff;
   logic                   out_valid_ff;
   logic                   out_bat_ff;
   logic                   out_pan_ff;
   logic [DacWidth-1:0]    out_dac_ff;
   logic                   out_write_ff;
   logic                   out_report_ff;

   logic                   out_free;
   logic                   s1_go;
   logic                   req_take;

   // handshake: the result register frees when empty or drained this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         battery_full_ff  <= BATTERY_FULL_RST;
         panel_on_ff      <= PANEL_ON_RST;
         battery_low_ff   <= BATTERY_LOW_RST;
         panel_low_ff     <= PANEL_LOW_RST;
         dac_step_ff      <= DAC_STEP_RST;
         dac_max_ff       <= DAC_MAX_RST;
         report_period_ff <= REPORT_PERIOD_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BATTERY_FULL:  battery_full_ff  <= csr_data;
            CSR_PANEL_ON:      panel_on_ff      <= csr_data;
            CSR_BATTERY_LOW:   battery_low_ff   <= csr_data;
            CSR_PANEL_LOW:     panel_low_ff     <= csr_data;
            CSR_DAC_STEP:      dac_step_ff      <= csr_data[StepWidth-1:0];
            CSR_DAC_MAX:       dac_max_ff       <= csr_data[DacWidth-1:0];
            CSR_REPORT_PERIOD: report_period_ff <= csr_data[PeriodWidth-1:0];
            default: ;  // index beyond the register list: drop the write
         endcase
      end
   end

   // control logic on the word in the input register
   logic                panel_on;
   logic                bat_full;
   logic                shutoff;
   logic [DacWidth:0]   level_up;
   logic [DacWidth:0]   level_step;
   logic [DacWidth-1:0] level_wide_max;

   always_comb begin
      panel_on = s1_word_ff.panel_volt_mv >= panel_on_ff;
      bat_full = s1_word_ff.battery_volt_mv >= battery_full_ff;
      shutoff  = (s1_word_ff.battery_volt_mv < battery_low_ff)
               && (s1_word_ff.panel_volt_mv < panel_low_ff);

      // battery switch: open when full, close when charging, then shutoff wins
      bat_level_in = bat_level_ff;
      if (bat_full) begin
         bat_level_in = 1'b0;
      end
      if (panel_on && !bat_full) begin
         bat_level_in = 1'b1;
      end
      if (shutoff) begin
         bat_level_in = 1'b0;
      end
      pan_level_in = panel_on;

      // tracking step; the sum is one bit wider to catch overflow past max
      level_up  = {1'b0, dac_level_ff} + {2'b00, dac_step_ff};
      level_step = {1'b0, dac_level_ff};
      peak_curr_in = peak_curr_ff;
      if (s1_word_ff.panel_curr_ma > peak_curr_ff) begin
         peak_curr_in = s1_word_ff.panel_curr_ma;
      end else if (s1_word_ff.panel_curr_ma < peak_curr_ff) begin
         if (s1_word_ff.panel_curr_ma > last_curr_ff) begin
            // current rose: step down, floor at zero
            if ({1'b0, dac_level_ff} < {2'b00, dac_step_ff}) begin
               level_step = '0;
            end else begin
               level_step = {1'b0, dac_level_ff} - {2'b00, dac_step_ff};
            end
         end else if (s1_word_ff.panel_curr_ma < last_curr_ff) begin
            level_step = level_up;
         end
      end
      level_wide_max = level_step[DacWidth-1:0];
      if (level_step > {1'b0, dac_max_ff}) begin
         level_wide_max = dac_max_ff;
      end

      // panel off: hold setpoint and current history
      if (panel_on) begin
         dac_level_in = level_wide_max;
         last_curr_in = s1_word_ff.panel_curr_ma;
         write_in     = 1'b1;
      end else begin
         dac_level_in = dac_level_ff;
         peak_curr_in = peak_curr_ff;
         last_curr_in = last_curr_ff;
         write_in     = 1'b0;
      end

      // report counter
      if (report_cnt_ff == report_period_ff) begin
         report_in     = 1'b1;
         report_cnt_in = '0;
      end else begin
         report_in     = 1'b0;
         report_cnt_in = report_cnt_ff + 1'b1;
      end
   end

   // state advances when the word leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         bat_level_ff  <= 1'b1;
         pan_level_ff  <= 1'b1;
         dac_level_ff  <= DAC_LEVEL_RST;
         peak_curr_ff  <= '0;
         last_curr_ff  <= '0;
         report_cnt_ff <= '0;
      end else if (s1_go) begin
         bat_level_ff  <= bat_level_in;
         pan_level_ff  <= pan_level_in;
         dac_level_ff  <= dac_level_in;
         peak_curr_ff  <= peak_curr_in;
         last_curr_ff  <= last_curr_in;
         report_cnt_ff <= report_cnt_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_word_ff.panel_volt_mv   <= req_panel_volt_mv;
         s1_word_ff.panel_curr_ma   <= req_panel_curr_ma;
         s1_word_ff.battery_volt_mv <= req_battery_volt_mv;
      end
   end

   // result register: load on advance, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_go) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         out_bat_ff    <= bat_level_in;
         out_pan_ff    <= pan_level_in;
         out_dac_ff    <= dac_level_in;
         out_write_ff  <= write_in;
         out_report_ff <= report_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_battery_switch  = out_bat_ff;
   assign rsp_panel_switch    = out_pan_ff;
   assign rsp_dac_setpoint_mv = out_dac_ff;
   assign rsp_dac_write       = out_write_ff;
   assign rsp_report_now      = out_report_ff;

endmodule

// ===== design/scsc_checker.sv =====
// Port-level checks for the solar charge switch controller.
// Watches the top level's ports only; bound to the top level below.
// Uses scsc_pkg for widths.
module scsc_port_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic                              rsp_panel_switch,
   input logic [scsc_pkg::DacWidth-1:0]     rsp_dac_setpoint_mv,
   input logic                              rsp_dac_write,
   input logic                              req_stall
);
   import scsc_pkg::*;

   // a reset cycle leaves no word in the result register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word present right after reset");

   // a stalled result word holds its setpoint
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_dac_setpoint_mv))
      else $error("stalled result word changed");

   // setpoint is written exactly on words with the panel switch closed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_dac_write == rsp_panel_switch)
      else $error("dac_write disagrees with panel switch");

   // an empty result register never backs up the input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled behind an empty result register");

endmodule

bind solar_charge_switch_controller scsc_port_checker u_scsc_port_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_panel_switch    (rsp_panel_switch),
   .rsp_dac_setpoint_mv (rsp_dac_setpoint_mv),
   .rsp_dac_write       (rsp_dac_write),
   .req_stall           (req_stall)
);

// ===== test/scsc_checker.sv =====
// Result checker for the solar charge switch controller: watches the sample, result
// and csr ports, predicts every result word and compares it with what the block gives.
// Depends on scsc_pkg for widths, register indexes and reset values.
module scsc_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [scsc_pkg::MvWidth-1:0]      req_panel_volt_mv,
   input  logic [scsc_pkg::MvWidth-1:0]      req_panel_curr_ma,
   input  logic [scsc_pkg::MvWidth-1:0]      req_battery_volt_mv,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic                              rsp_battery_switch,
   input  logic                              rsp_panel_switch,
   input  logic [scsc_pkg::DacWidth-1:0]     rsp_dac_setpoint_mv,
   input  logic                              rsp_dac_write,
   input  logic                              rsp_report_now,
   input  logic                              csr_write,
   input  logic [scsc_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [scsc_pkg::CsrDataWidth-1:0] csr_data,
   output int                                mismatch_count,
   output int                                words_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import scsc_pkg::*;

   typedef struct packed {
      logic                battery_switch;
      logic                panel_switch;
      logic [DacWidth-1:0] dac_setpoint_mv;
      logic                dac_write;
      logic                report_now;
   } status_word_type;

   // register copies
   logic [MvWidth-1:0]     full_mv;
   logic [MvWidth-1:0]     on_mv;
   logic [MvWidth-1:0]     low_mv;
   logic [MvWidth-1:0]     plow_mv;
   logic [StepWidth-1:0]   step_mv;
   logic [DacWidth-1:0]    max_mv;
   logic [PeriodWidth-1:0] period;

   // controller state
   logic                   bat_closed;
   logic                   pan_closed;
   logic [DacWidth-1:0]    dac_level;
   logic [MvWidth-1:0]     peak_ma;
   logic [MvWidth-1:0]     last_ma;
   logic [PeriodWidth-1:0] sample_count;

   status_word_type expected_words[$];
   int              words_checked;

   // Advance the controller by one sample set and return the word it gives.
   function automatic status_word_type advance_controller(input logic [MvWidth-1:0] pv,
                                                          input logic [MvWidth-1:0] pc,
                                                          input logic [MvWidth-1:0] bv);
      status_word_type word;
      int              level;
      word = '0;
      if (bv >= full_mv) bat_closed = 1'b0;
      if (pv >= on_mv) begin
         level = int'(dac_level);
         pan_closed = 1'b1;
         if (bv < full_mv) bat_closed = 1'b1;
         if (pc > peak_ma) begin
            peak_ma = pc;
         end else if (pc < peak_ma) begin
            if (pc > last_ma) level -= int'(step_mv);
            else if (pc < last_ma) level += int'(step_mv);
         end
         if (level > int'(max_mv)) level = int'(max_mv);
         else if (level < 0) level = 0;
         dac_level = DacWidth'(level);
         word.dac_write = 1'b1;
         last_ma = pc;
      end else begin
         pan_closed = 1'b0;
      end
      // low battery with a weak panel overrides any close above
      if (bv < low_mv && pv < plow_mv) bat_closed = 1'b0;
      if (sample_count == period) begin
         word.report_now = 1'b1;
         sample_count = '0;
      end else begin
         sample_count = sample_count + 1'b1;
      end
      word.battery_switch  = bat_closed;
      word.panel_switch    = pan_closed;
      word.dac_setpoint_mv = dac_level;
      return word;
   endfunction

   task automatic report_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t ns: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      status_word_type seen;
      status_word_type want;
      if (reset) begin
         full_mv = BATTERY_FULL_RST;
         on_mv = PANEL_ON_RST;
         low_mv = BATTERY_LOW_RST;
         plow_mv = PANEL_LOW_RST;
         step_mv = DAC_STEP_RST;
         max_mv = DAC_MAX_RST;
         period = REPORT_PERIOD_RST;
         bat_closed = 1'b1;
         pan_closed = 1'b1;
         dac_level = DAC_LEVEL_RST;
         peak_ma = '0;
         last_ma = '0;
         sample_count = '0;
         expected_words.delete();
         words_checked = 0;
         mismatch_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_battery_switch, rsp_panel_switch, rsp_dac_setpoint_mv,
                    rsp_dac_write, rsp_report_now};
            if (expected_words.size() == 0) begin
               report_failure($sformatf("result word %0d arrived with none expected",
                                        words_checked));
            end else begin
               want = expected_words.pop_front();
               if (seen !== want)
                  report_failure($sformatf({"result word %0d: battery_switch %b/%b ",
                     "panel_switch %b/%b dac_setpoint_mv %0d/%0d dac_write %b/%b ",
                     "report_now %b/%b (expected/actual)"}, words_checked,
                     want.battery_switch, seen.battery_switch,
                     want.panel_switch, seen.panel_switch,
                     want.dac_setpoint_mv, seen.dac_setpoint_mv,
                     want.dac_write, seen.dac_write,
                     want.report_now, seen.report_now));
            end
            words_checked++;
         end
         if (req_valid && !req_stall)
            expected_words.push_back(advance_controller(req_panel_volt_mv,
                                                        req_panel_curr_ma,
                                                        req_battery_volt_mv));
         if (csr_write) begin
            case (csr_index)
               CSR_BATTERY_FULL:  full_mv = csr_data;
               CSR_PANEL_ON:      on_mv = csr_data;
               CSR_BATTERY_LOW:   low_mv = csr_data;
               CSR_PANEL_LOW:     plow_mv = csr_data;
               CSR_DAC_STEP:      step_mv = csr_data[StepWidth-1:0];
               CSR_DAC_MAX:       max_mv = csr_data[DacWidth-1:0];
               CSR_REPORT_PERIOD: period = csr_data[PeriodWidth-1:0];
               default: ;
            endcase
         end
      end
      words_pending <= expected_words.size();
   end

endmodule

// ===== test/testbench.sv =====
// Top of the solar charge switch controller testbench: clock, reset, sample and
// csr stimulus, random stalls on the result side, and the final verdict.
// Depends on scsc_pkg, solar_charge_switch_controller and scsc_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import scsc_pkg::*;

   localparam int CycleLimit = 400_000;
   localparam int MaxMv      = 65535;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [MvWidth-1:0]      req_panel_volt_mv = '0;
   logic [MvWidth-1:0]      req_panel_curr_ma = '0;
   logic [MvWidth-1:0]      req_battery_volt_mv = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_battery_switch;
   logic                    rsp_panel_switch;
   logic [DacWidth-1:0]     rsp_dac_setpoint_mv;
   logic                    rsp_dac_write;
   logic                    rsp_report_now;
   logic                    csr_write = 1'b0;
   logic [CsrIdxWidth-1:0]  csr_index = '0;
   logic [CsrDataWidth-1:0] csr_data = '0;

   int mismatch_count;
   int words_pending;
   int cycle_count = 0;

   // threshold copies used only to aim the random samples near the edges
   int cfg_full_mv;
   int cfg_on_mv;
   int cfg_low_mv;
   int cfg_plow_mv;

   // panel current random walk and its ceiling for the current phase
   int ma_level = 0;
   int ma_ceiling = 3000;

   // while set, neither side idles
   bit steady = 1'b0;

   solar_charge_switch_controller DUT (.*);
   scsc_checker status_check (.*);

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   function automatic int clamp_mv(input int v);
      if (v < 0) return 0;
      if (v > MaxMv) return MaxMv;
      return v;
   endfunction

   // Pick a value on, just under, around or far from a threshold.
   function automatic int near_mv(input int thr);
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0:       return thr;
         1:       return clamp_mv(thr - 1);
         2, 3:    return clamp_mv(thr + int'($urandom_range(0, 2000)));
         4, 5:    return clamp_mv(thr - int'($urandom_range(0, 2000)));
         default: return $urandom_range(0, MaxMv);
      endcase
   endfunction

   // Result side: hold stall for a random stretch, then release it for a while.
   always @(posedge clock) begin
      int stall_left;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         stall_left = steady ? 0 : $urandom_range(0, 5);
      end else if (!steady) begin
         stall_left = pick_gap();
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end
      end
   end

   // Offer one sample word, after an optional idle gap, and wait until it is taken.
   task automatic send_word(input int pv, input int pc, input int bv);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_panel_volt_mv <= MvWidth'(pv);
      req_panel_curr_ma <= MvWidth'(pc);
      req_battery_volt_mv <= MvWidth'(bv);
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and hold until every predicted result word has been taken.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
   endtask

   task automatic write_reg(input logic [CsrIdxWidth-1:0] idx, input int value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= CsrDataWidth'(value);
      @(posedge clock);
   endtask

   // Drain the block, then write all seven registers back to back.
   task automatic configure(input int full, input int on, input int low, input int plow,
                            input int step, input int dmax, input int period);
      wait_idle();
      write_reg(CSR_BATTERY_FULL, full);
      write_reg(CSR_PANEL_ON, on);
      write_reg(CSR_BATTERY_LOW, low);
      write_reg(CSR_PANEL_LOW, plow);
      write_reg(CSR_DAC_STEP, step);
      write_reg(CSR_DAC_MAX, dmax);
      write_reg(CSR_REPORT_PERIOD, period);
      csr_write <= 1'b0;
      cfg_full_mv = full;
      cfg_on_mv = on;
      cfg_low_mv = low;
      cfg_plow_mv = plow;
   endtask

   // One random sample set: panel voltage mostly above the on threshold so that
   // tracking runs, battery voltage around the full and low thresholds, and the
   // current as a random walk with repeats and jumps.
   task automatic send_random_word();
      int pv;
      int bv;
      int r;
      int delta;
      r = $urandom_range(0, 99);
      if (r < 50) pv = clamp_mv(cfg_on_mv + int'($urandom_range(0, 12000)));
      else if (r < 70) pv = near_mv(cfg_on_mv);
      else if (r < 85) pv = near_mv(cfg_plow_mv);
      else pv = $urandom_range(0, MaxMv);
      r = $urandom_range(0, 99);
      if (r < 45) bv = near_mv(cfg_full_mv);
      else if (r < 90) bv = near_mv(cfg_low_mv);
      else bv = $urandom_range(0, MaxMv);
      r = $urandom_range(0, 99);
      if (r < 15) begin
         // repeat the last current: no step
      end else if (r < 85) begin
         delta = $urandom_range(0, 600);
         ma_level += delta - 300;
      end else begin
         ma_level = $urandom_range(0, ma_ceiling);
      end
      if (ma_level < 0) ma_level = 0;
      if (ma_level > ma_ceiling) ma_level = ma_ceiling;
      send_word(pv, ma_level, bv);
   endtask

   initial begin
      int phase_items;
      int period;
      cfg_full_mv = int'(BATTERY_FULL_RST);
      cfg_on_mv = int'(PANEL_ON_RST);
      cfg_low_mv = int'(BATTERY_LOW_RST);
      cfg_plow_mv = int'(PANEL_LOW_RST);
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed words at reset settings: threshold edges, peak tracking and
      // every step direction.
      send_word(0, 0, 0);               // panel off, low battery shutoff
      send_word(MaxMv, 1000, MaxMv);    // battery full opens, first peak
      send_word(20000, 1000, 11999);    // panel exactly on, battery just below full
      send_word(19999, 900, 11999);     // panel just off: setpoint held
      send_word(20000, 800, 12000);     // battery exactly full; fell: step up, clamp
      send_word(25000, 900, 11000);     // rose below peak: step down
      send_word(25000, 950, 11000);
      send_word(25000, 950, 11000);     // unchanged: no step
      send_word(25000, 700, 11000);     // fell: step up
      send_word(25000, 1000, 11000);    // equal to peak: no step
      send_word(25000, 1500, 11000);    // new peak
      send_word(29999, 100, 10499);     // close then shutoff in the same word
      send_word(30000, 100, 10499);     // panel exactly at the low limit: no shutoff
      send_word(19999, 100, 10500);     // battery exactly at low
      send_word(19999, 100, 10499);     // panel off and low battery: shutoff

      // Large steps: push the setpoint down onto its zero floor, then up into the clamp.
      configure(12000, 20000, 10500, 30000, 1200, 4095, 3);
      send_word(25000, 200, 11000);
      send_word(25000, 300, 11000);
      send_word(25000, 400, 11000);
      send_word(25000, 500, 11000);
      send_word(25000, 450, 11000);
      send_word(25000, 400, 11000);
      send_word(25000, 350, 11000);
      send_word(25000, 300, 11000);

      // Lower the clamp under the held level; set the report period to zero.
      configure(12000, 20000, 10500, 30000, 1200, 500, 0);
      send_word(25000, 300, 11000);
      send_word(0, 300, 11000);

      // Random phases, each with its own register settings.
      for (int phase = 0; phase < 10; phase++) begin
         period = $urandom_range(0, 40);
         case (phase)
            0: configure(int'(BATTERY_FULL_RST), int'(PANEL_ON_RST),
                         int'(BATTERY_LOW_RST), int'(PANEL_LOW_RST),
                         int'(DAC_STEP_RST), int'(DAC_MAX_RST), int'(REPORT_PERIOD_RST));
            1: configure(0, 0, 0, 0, 0, 0, 0);
            2: configure(MaxMv, MaxMv, MaxMv, MaxMv, 1200, 4095, 255);
            default: begin
               // after the long period, a short one leaves the counter above it
               if (phase == 3) period = 7;
               else if ($urandom_range(0, 3) == 0) period = $urandom_range(0, 255);
               configure($urandom_range(8000, 16000), $urandom_range(5000, 40000),
                         $urandom_range(8000, 12000), $urandom_range(10000, 45000),
                         $urandom_range(0, 1200), $urandom_range(0, 4095), period);
            end
         endcase
         // raise the current ceiling each phase so new peaks keep coming
         ma_ceiling = (phase == 9) ? MaxMv : 3000 * (phase + 1);
         phase_items = (phase == 3) ? 170 : 110;
         repeat (phase_items) begin
            if ($urandom_range(0, 49) == 0) steady = !steady;
            if ($urandom_range(0, 99) == 0) wait_idle();
            send_random_word();
         end
      end

      steady = 1'b0;
      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && words_pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/scsc_pkg.sv
design/solar_charge_switch_controller.sv
design/scsc_checker.sv
test/scsc_checker.sv
test/testbench.sv
